>>> hw/rtl/stk_pkg.sv
// Package for the source tokenizer: result and burst types, scan modes,
// token type and fault codes, and the keyword table. No dependencies.
package stk_pkg;

    localparam int LINE_BITS = 16;
    localparam int COLUMN_BITS = 16;
    localparam int MAX_RES = 6;
    localparam int RES_IDX_BITS = $clog2(MAX_RES + 1);
    localparam int NUM_KW = 12;

    typedef logic [LINE_BITS-1:0] line_t;
    typedef logic [COLUMN_BITS-1:0] col_t;

    localparam line_t LINE_MAX = {LINE_BITS{1'b1}};
    localparam col_t COL_MAX = {COLUMN_BITS{1'b1}};

    typedef enum logic [3:0] {
        MD_IDLE, MD_COMMENT, MD_SPACES, MD_AFTER_CR, MD_OP, MD_INT, MD_DOT,
        MD_FRAC, MD_WORD, MD_STR, MD_ESC, MD_DRAIN
    } mode_t;

    localparam logic [1:0] K_TEXT = 2'd0;
    localparam logic [1:0] K_TOKEN = 2'd1;
    localparam logic [1:0] K_ERROR = 2'd2;
    localparam logic [1:0] K_END = 2'd3;

    localparam logic [1:0] F_UNTERM = 2'd0;
    localparam logic [1:0] F_NEWLINE = 2'd1;
    localparam logic [1:0] F_ESCAPE = 2'd2;
    localparam logic [1:0] F_SYMBOL = 2'd3;
    localparam logic [1:0] F_NONE = 2'd0;

    localparam logic [5:0] TY_EOF = 6'd0;
    localparam logic [5:0] TY_WORD = 6'd2;
    localparam logic [5:0] TY_STRING = 6'd3;
    localparam logic [5:0] TY_INT = 6'd4;
    localparam logic [5:0] TY_FLOAT = 6'd5;
    localparam logic [5:0] TY_BOOL = 6'd6;
    localparam logic [5:0] TY_LPAREN = 6'd7;
    localparam logic [5:0] TY_RPAREN = 6'd8;
    localparam logic [5:0] TY_LBRACE = 6'd9;
    localparam logic [5:0] TY_RBRACE = 6'd10;
    localparam logic [5:0] TY_LBRACKET = 6'd11;
    localparam logic [5:0] TY_RBRACKET = 6'd12;
    localparam logic [5:0] TY_COMMA = 6'd13;
    localparam logic [5:0] TY_SEMI = 6'd14;
    localparam logic [5:0] TY_PLUS = 6'd15;
    localparam logic [5:0] TY_MINUS = 6'd16;
    localparam logic [5:0] TY_STAR = 6'd17;
    localparam logic [5:0] TY_SLASH = 6'd18;
    localparam logic [5:0] TY_PERCENT = 6'd19;
    localparam logic [5:0] TY_ASSIGN = 6'd20;
    localparam logic [5:0] TY_DEFINE = 6'd21;
    localparam logic [5:0] TY_NEQ = 6'd22;
    localparam logic [5:0] TY_BANG = 6'd23;
    localparam logic [5:0] TY_DOT = 6'd24;
    localparam logic [5:0] TY_SHL = 6'd25;
    localparam logic [5:0] TY_SHR = 6'd26;
    localparam logic [5:0] TY_LE = 6'd27;
    localparam logic [5:0] TY_GE = 6'd28;
    localparam logic [5:0] TY_LT = 6'd29;
    localparam logic [5:0] TY_GT = 6'd30;
    localparam logic [5:0] TY_ANDAND = 6'd31;
    localparam logic [5:0] TY_OROR = 6'd32;
    localparam logic [5:0] TY_AMP = 6'd33;
    localparam logic [5:0] TY_PIPE = 6'd34;
    localparam logic [5:0] TY_CARET = 6'd35;
    localparam logic [5:0] TY_TILDE = 6'd36;
    localparam logic [5:0] TY_SCOPE = 6'd37;
    localparam logic [5:0] TY_COLON = 6'd38;
    localparam logic [5:0] TY_ARROW = 6'd39;
    localparam logic [5:0] TY_AT = 6'd40;
    localparam logic [5:0] TY_RETURN = 6'd49;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text_byte;
        logic [5:0] tok_type;
        line_t tok_line;
        col_t tok_column;
        logic [1:0] fault_code;
    } result_t;

    typedef struct packed {
        result_t [MAX_RES-1:0] res;
        logic [RES_IDX_BITS-1:0] count;
    } burst_t;

    // Keyword spellings, padded with zero bytes to eight characters.
    localparam logic [7:0] KW_CHAR [NUM_KW][8] = '{
        '{"u", "s", "i", "n", "g", 8'h00, 8'h00, 8'h00},
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"t", "y", "p", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"N", "o", "n", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd5, 3'd3, 3'd3, 3'd4, 3'd2, 3'd4, 3'd5, 3'd4, 3'd6, 3'd4, 3'd4, 3'd5
    };
    localparam logic [5:0] KW_TYPE [NUM_KW] = '{
        6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, TY_RETURN, 6'd50,
        TY_BOOL, TY_BOOL
    };

endpackage

>>> hw/rtl/stk_if.sv
// Channel interfaces of the source tokenizer: source bytes in, results out.
// Depends on stk_pkg for the field widths.
interface stk_src_if;
    logic valid;
    logic ready;
    logic [7:0] src_byte;
    logic end_of_source;

    modport source (output valid, output src_byte, output end_of_source, input ready);
    modport sink (input valid, input src_byte, input end_of_source, output ready);
endinterface

interface stk_res_if import stk_pkg::*;;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [7:0] text_byte;
    logic [5:0] tok_type;
    line_t tok_line;
    col_t tok_column;
    logic [1:0] fault_code;
    logic run_last;

    modport source (output valid, output kind, output text_byte, output tok_type,
                    output tok_line, output tok_column, output fault_code,
                    output run_last, input ready);
    modport sink (input valid, input kind, input text_byte, input tok_type,
                  input tok_line, input tok_column, input fault_code,
                  input run_last, output ready);
endinterface

>>> hw/rtl/stk_front.sv
// Scanner front end: takes one source byte per request, runs the lexer state
// and builds the burst of results it causes. Depends on stk_pkg and stk_if.
module stk_front import stk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    stk_src_if.sink src,
    output logic push,
    output burst_t push_data,
    input  logic push_ready
);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_BS = 8'h08;

    mode_t mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic [5:0] prev_reg, prev_next;
    line_t cl_reg, cl_next, sl_reg, sl_next;
    col_t cc_reg, cc_next, sc_reg, sc_next;
    logic [NUM_KW-1:0] kh_reg, kh_next;
    logic [2:0] wl_reg, wl_next;

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF
            || c == CH_CR;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_wstart(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic can_extend(input logic [7:0] c);
        return c == "-" || c == ":" || c == "!" || c == "<" || c == ">" || c == "&"
            || c == "|";
    endfunction

    function automatic logic [5:0] single_type(input logic [7:0] c);
        logic [5:0] t;
        case (c)
            "(": t = TY_LPAREN;
            ")": t = TY_RPAREN;
            "[": t = TY_LBRACKET;
            "]": t = TY_RBRACKET;
            "{": t = TY_LBRACE;
            "}": t = TY_RBRACE;
            ",": t = TY_COMMA;
            ";": t = TY_SEMI;
            "+": t = TY_PLUS;
            "-": t = TY_MINUS;
            "*": t = TY_STAR;
            "/": t = TY_SLASH;
            "%": t = TY_PERCENT;
            "=": t = TY_ASSIGN;
            "!": t = TY_BANG;
            ".": t = TY_DOT;
            "<": t = TY_LT;
            ">": t = TY_GT;
            "&": t = TY_AMP;
            "|": t = TY_PIPE;
            "^": t = TY_CARET;
            "~": t = TY_TILDE;
            ":": t = TY_COLON;
            "@": t = TY_AT;
            default: t = TY_EOF;
        endcase
        return t;
    endfunction

    function automatic logic [5:0] pair_type(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] t;
        t = TY_EOF;
        if (a == "-" && b == ">") t = TY_ARROW;
        if (a == ":" && b == "=") t = TY_DEFINE;
        if (a == ":" && b == ":") t = TY_SCOPE;
        if (a == "!" && b == "=") t = TY_NEQ;
        if (a == "<" && b == "<") t = TY_SHL;
        if (a == "<" && b == "=") t = TY_LE;
        if (a == ">" && b == ">") t = TY_SHR;
        if (a == ">" && b == "=") t = TY_GE;
        if (a == "&" && b == "&") t = TY_ANDAND;
        if (a == "|" && b == "|") t = TY_OROR;
        return t;
    endfunction

    function automatic logic is_closing(input logic [5:0] t);
        return t == TY_WORD || t == TY_STRING || t == TY_INT || t == TY_FLOAT
            || t == TY_BOOL || t == TY_RETURN || t == TY_RPAREN || t == TY_RBRACKET
            || t == TY_RBRACE;
    endfunction

    function automatic logic [NUM_KW-1:0] kw_feed(input logic [NUM_KW-1:0] kh,
                                                 input logic [2:0] wl,
                                                 input logic [7:0] c);
        logic [NUM_KW-1:0] r;
        r = kh;
        for (int i = 0; i < NUM_KW; i++) begin
            if (!(wl < KW_LEN[i] && KW_CHAR[i][wl] == c)) r[i] = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [5:0] kw_type(input logic [NUM_KW-1:0] kh,
                                          input logic [2:0] wl);
        logic [5:0] t;
        t = TY_WORD;
        for (int i = 0; i < NUM_KW; i++) begin
            if (kh[i] && KW_LEN[i] == wl) t = KW_TYPE[i];
        end
        return t;
    endfunction

    // Escape decode; the top bit flags an unknown escape.
    function automatic logic [8:0] esc_value(input logic [7:0] c);
        logic [8:0] v;
        case (c)
            "\"": v = {1'b0, 8'h22};
            "\\": v = {1'b0, 8'h5C};
            "b": v = {1'b0, CH_BS};
            "n": v = {1'b0, CH_LF};
            "r": v = {1'b0, CH_CR};
            "t": v = {1'b0, CH_TAB};
            "v": v = {1'b0, CH_VT};
            "f": v = {1'b0, CH_FF};
            default: v = 9'h100;
        endcase
        return v;
    endfunction

    function automatic result_t mk(input logic [1:0] kind, input logic [7:0] b,
                                   input logic [5:0] t, input line_t l, input col_t cv,
                                   input logic [1:0] f);
        result_t r;
        r.kind = kind;
        r.text_byte = b;
        r.tok_type = t;
        r.tok_line = l;
        r.tok_column = cv;
        r.fault_code = f;
        return r;
    endfunction

    function automatic burst_t put(input burst_t bu, input result_t r);
        burst_t o;
        o = bu;
        if (o.count < RES_IDX_BITS'(MAX_RES)) begin
            o.res[o.count] = r;
            o.count = o.count + 1'b1;
        end
        return o;
    endfunction

    logic fire;
    assign src.ready = push_ready;
    assign fire = src.valid && push_ready;

    always_comb
    begin
        logic [7:0] c;
        logic eos, disp, nl;
        logic [5:0] t;
        logic [8:0] ev;
        col_t dc;
        burst_t bu;

        mode_next = mode_reg;
        held_next = held_reg;
        prev_next = prev_reg;
        cl_next = cl_reg;
        cc_next = cc_reg;
        sl_next = sl_reg;
        sc_next = sc_reg;
        kh_next = kh_reg;
        wl_next = wl_reg;
        c = src.src_byte;
        eos = src.end_of_source;
        disp = 1'b0;
        nl = 1'b0;
        t = TY_EOF;
        ev = '0;
        dc = '0;
        bu = '0;

        if (c != CH_NUL && mode_reg != MD_DRAIN) begin
            case (mode_reg)
                MD_IDLE: disp = 1'b1;
                MD_COMMENT:
                begin
                    if (c == CH_LF) nl = 1'b1;
                    else if (c == CH_CR) mode_next = MD_AFTER_CR;
                end
                MD_SPACES:
                begin
                    if (c == "#")
                    begin
                        sl_next = cl_next;
                        sc_next = cc_next;
                        mode_next = MD_COMMENT;
                    end
                    else if (c == CH_LF) nl = 1'b1;
                    else if (c == CH_CR) mode_next = MD_AFTER_CR;
                    else if (!is_blank(c)) disp = 1'b1;
                end
                MD_AFTER_CR:
                begin
                    if (c == CH_LF) nl = 1'b1;
                    else disp = 1'b1;
                end
                MD_OP:
                begin
                    t = pair_type(held_next, c);
                    bu = put(bu, mk(K_TEXT, held_next, TY_EOF, sl_next, sc_next, F_NONE));
                    if (t != TY_EOF)
                    begin
                        bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                        bu = put(bu, mk(K_TOKEN, 8'h00, t, sl_next, sc_next, F_NONE));
                        prev_next = t;
                        mode_next = MD_IDLE;
                    end
                    else
                    begin
                        t = single_type(held_next);
                        bu = put(bu, mk(K_TOKEN, 8'h00, t, sl_next, sc_next, F_NONE));
                        prev_next = t;
                        disp = 1'b1;
                    end
                end
                MD_INT:
                begin
                    if (is_digit(c))
                        bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                    else if (c == ".")
                    begin
                        held_next = {7'd0, cc_next >= COL_MAX};
                        mode_next = MD_DOT;
                    end
                    else
                    begin
                        bu = put(bu, mk(K_TOKEN, 8'h00, TY_INT, sl_next, sc_next, F_NONE));
                        prev_next = TY_INT;
                        disp = 1'b1;
                    end
                end
                MD_DOT:
                begin
                    if (is_digit(c))
                    begin
                        bu = put(bu, mk(K_TEXT, ".", TY_EOF, sl_next, sc_next, F_NONE));
                        bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                        mode_next = MD_FRAC;
                    end
                    else
                    begin
                        dc = (held_next != 8'h00) ? COL_MAX : cc_next - 1'b1;
                        bu = put(bu, mk(K_TOKEN, 8'h00, TY_INT, sl_next, sc_next, F_NONE));
                        bu = put(bu, mk(K_TEXT, ".", TY_EOF, cl_next, dc, F_NONE));
                        bu = put(bu, mk(K_TOKEN, 8'h00, TY_DOT, cl_next, dc, F_NONE));
                        prev_next = TY_DOT;
                        disp = 1'b1;
                    end
                end
                MD_FRAC:
                begin
                    if (is_digit(c))
                        bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                    else
                    begin
                        bu = put(bu, mk(K_TOKEN, 8'h00, TY_FLOAT, sl_next, sc_next,
                                        F_NONE));
                        prev_next = TY_FLOAT;
                        disp = 1'b1;
                    end
                end
                MD_WORD:
                begin
                    if (is_wstart(c) || is_digit(c))
                    begin
                        kh_next = kw_feed(kh_next, wl_next, c);
                        if (wl_next < 3'd7) wl_next = wl_next + 1'b1;
                        bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                    end
                    else
                    begin
                        t = kw_type(kh_next, wl_next);
                        bu = put(bu, mk(K_TOKEN, 8'h00, t, sl_next, sc_next, F_NONE));
                        prev_next = t;
                        disp = 1'b1;
                    end
                end
                MD_STR:
                begin
                    if (c == "\"")
                    begin
                        bu = put(bu, mk(K_TOKEN, 8'h00, TY_STRING, sl_next, sc_next,
                                        F_NONE));
                        prev_next = TY_STRING;
                        mode_next = MD_IDLE;
                    end
                    else if (c == CH_LF || c == CH_CR)
                    begin
                        bu = put(bu, mk(K_ERROR, 8'h00, TY_EOF, sl_next, sc_next,
                                        F_NEWLINE));
                        mode_next = MD_DRAIN;
                    end
                    else if (c == "\\") mode_next = MD_ESC;
                    else bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                end
                MD_ESC:
                begin
                    ev = esc_value(c);
                    if (!ev[8])
                    begin
                        bu = put(bu, mk(K_TEXT, ev[7:0], TY_EOF, sl_next, sc_next, F_NONE));
                        mode_next = MD_STR;
                    end
                    else
                    begin
                        bu = put(bu, mk(K_ERROR, 8'h00, TY_EOF, sl_next, sc_next,
                                        F_ESCAPE));
                        mode_next = MD_DRAIN;
                    end
                end
                default: ;
            endcase

            if (disp)
            begin
                mode_next = MD_IDLE;
                if (is_blank(c) || c == "#")
                begin
                    sl_next = cl_next;
                    sc_next = cc_next;
                    if (c == "#") mode_next = MD_COMMENT;
                    else if (c == CH_CR) mode_next = MD_AFTER_CR;
                    else if (c == CH_LF) nl = 1'b1;
                    else mode_next = MD_SPACES;
                end
                else if (c == "?" || c == "$")
                begin
                    bu = put(bu, mk(K_END, 8'h00, TY_EOF, cl_next, cc_next, F_NONE));
                    mode_next = MD_DRAIN;
                end
                else if (can_extend(c))
                begin
                    sl_next = cl_next;
                    sc_next = cc_next;
                    held_next = c;
                    mode_next = MD_OP;
                end
                else if (single_type(c) != TY_EOF)
                begin
                    sl_next = cl_next;
                    sc_next = cc_next;
                    bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                    bu = put(bu, mk(K_TOKEN, 8'h00, single_type(c), sl_next, sc_next,
                                    F_NONE));
                    prev_next = single_type(c);
                end
                else if (is_digit(c))
                begin
                    sl_next = cl_next;
                    sc_next = cc_next;
                    bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                    mode_next = MD_INT;
                end
                else if (is_wstart(c))
                begin
                    sl_next = cl_next;
                    sc_next = cc_next;
                    kh_next = kw_feed({NUM_KW{1'b1}}, 3'd0, c);
                    wl_next = 3'd1;
                    bu = put(bu, mk(K_TEXT, c, TY_EOF, sl_next, sc_next, F_NONE));
                    mode_next = MD_WORD;
                end
                else if (c == "\"")
                begin
                    sl_next = cl_next;
                    sc_next = cc_next;
                    mode_next = MD_STR;
                end
                else
                begin
                    bu = put(bu, mk(K_ERROR, 8'h00, TY_EOF, cl_next, cc_next, F_SYMBOL));
                    mode_next = MD_DRAIN;
                end
            end

            if (nl)
            begin
                if (cl_next < LINE_MAX) cl_next = cl_next + 1'b1;
                if (is_closing(prev_next))
                begin
                    bu = put(bu, mk(K_TOKEN, 8'h00, TY_SEMI, sl_next, sc_next, F_NONE));
                    prev_next = TY_SEMI;
                end
                mode_next = MD_IDLE;
            end

            if (c == CH_LF) cc_next = col_t'(1);
            else if (cc_next < COL_MAX) cc_next = cc_next + 1'b1;
        end

        if (c == CH_NUL || eos)
        begin
            case (mode_next)
                MD_OP:
                begin
                    bu = put(bu, mk(K_TEXT, held_next, TY_EOF, sl_next, sc_next, F_NONE));
                    bu = put(bu, mk(K_TOKEN, 8'h00, single_type(held_next), sl_next,
                                    sc_next, F_NONE));
                    bu = put(bu, mk(K_END, 8'h00, TY_EOF, cl_next, cc_next, F_NONE));
                end
                MD_INT:
                begin
                    bu = put(bu, mk(K_TOKEN, 8'h00, TY_INT, sl_next, sc_next, F_NONE));
                    bu = put(bu, mk(K_END, 8'h00, TY_EOF, cl_next, cc_next, F_NONE));
                end
                MD_DOT:
                begin
                    dc = (held_next != 8'h00) ? COL_MAX : cc_next - 1'b1;
                    bu = put(bu, mk(K_TOKEN, 8'h00, TY_INT, sl_next, sc_next, F_NONE));
                    bu = put(bu, mk(K_TEXT, ".", TY_EOF, cl_next, dc, F_NONE));
                    bu = put(bu, mk(K_TOKEN, 8'h00, TY_DOT, cl_next, dc, F_NONE));
                    bu = put(bu, mk(K_END, 8'h00, TY_EOF, cl_next, cc_next, F_NONE));
                end
                MD_FRAC:
                begin
                    bu = put(bu, mk(K_TOKEN, 8'h00, TY_FLOAT, sl_next, sc_next, F_NONE));
                    bu = put(bu, mk(K_END, 8'h00, TY_EOF, cl_next, cc_next, F_NONE));
                end
                MD_WORD:
                begin
                    bu = put(bu, mk(K_TOKEN, 8'h00, kw_type(kh_next, wl_next), sl_next,
                                    sc_next, F_NONE));
                    bu = put(bu, mk(K_END, 8'h00, TY_EOF, cl_next, cc_next, F_NONE));
                end
                MD_STR:
                    bu = put(bu, mk(K_ERROR, 8'h00, TY_EOF, sl_next, sc_next, F_UNTERM));
                MD_ESC:
                    bu = put(bu, mk(K_ERROR, 8'h00, TY_EOF, sl_next, sc_next, F_ESCAPE));
                MD_DRAIN: ;
                default:
                    bu = put(bu, mk(K_END, 8'h00, TY_EOF, cl_next, cc_next, F_NONE));
            endcase
            // A new source starts from the reset state.
            mode_next = MD_IDLE;
            held_next = 8'h00;
            prev_next = TY_EOF;
            cl_next = line_t'(1);
            cc_next = col_t'(1);
            sl_next = line_t'(1);
            sc_next = col_t'(1);
            kh_next = {NUM_KW{1'b1}};
            wl_next = 3'd0;
        end

        push_data = bu;
        push = fire && (bu.count != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MD_IDLE;
            held_reg <= 8'h00;
            prev_reg <= TY_EOF;
            cl_reg <= line_t'(1);
            cc_reg <= col_t'(1);
            sl_reg <= line_t'(1);
            sc_reg <= col_t'(1);
            kh_reg <= {NUM_KW{1'b1}};
            wl_reg <= 3'd0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            prev_reg <= prev_next;
            cl_reg <= cl_next;
            cc_reg <= cc_next;
            sl_reg <= sl_next;
            sc_reg <= sc_next;
            kh_reg <= kh_next;
            wl_reg <= wl_next;
        end
    end

endmodule

>>> hw/rtl/stk_queue.sv
// Two-entry queue of result bursts between the scanner and the output side.
// Depends on stk_pkg.
module stk_queue import stk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  burst_t push_data,
    output logic push_ready,
    output logic pop_valid,
    output burst_t pop_data,
    input  logic pop
);

    burst_t mem [2];
    logic wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid = cnt_reg != 2'd0;
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) mem[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_reg <= !wr_reg;
            if (pop) rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> hw/rtl/stk_back.sv
// Output side: loads a burst from the queue and hands its results out one
// request at a time, marking the last. Depends on stk_pkg and stk_if.
module stk_back import stk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pop_valid,
    input  burst_t pop_data,
    output logic pop,
    stk_res_if.source res
);

    logic busy_reg;
    burst_t burst_reg;
    logic [RES_IDX_BITS-1:0] idx_reg;
    logic last, fire;
    result_t cur;

    assign cur = burst_reg.res[idx_reg];
    assign last = idx_reg == burst_reg.count - 1'b1;
    assign fire = res.valid && res.ready;
    assign pop = pop_valid && (!busy_reg || (fire && last));

    assign res.valid = busy_reg;
    assign res.kind = cur.kind;
    assign res.text_byte = cur.text_byte;
    assign res.tok_type = cur.tok_type;
    assign res.tok_line = cur.tok_line;
    assign res.tok_column = cur.tok_column;
    assign res.fault_code = cur.fault_code;
    assign res.run_last = last;

    always_ff @(posedge clk)
    begin
        if (pop) burst_reg <= pop_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (fire)
        begin
            if (last) busy_reg <= 1'b0;
            else idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule

>>> hw/rtl/source_tokenizer.sv
// Top level of the source tokenizer: scanner, burst queue and output side.
// Depends on stk_pkg, stk_if, stk_front, stk_queue and stk_back.
//
//   channel   direction   payload
//   src       in          src_byte, end_of_source
//   res       out         kind, text_byte, tok_type, tok_line, tok_column,
//                         fault_code, run_last
//
// The scanner takes one byte per cycle whenever the queue has room and
// writes all results of that byte as one burst; the output side sends one
// result per cycle while the receiver is ready.
// Reset puts the scanner between tokens at line 1, column 1 with empty queue.
// Either side may stall; the two-burst queue lets them stall independently.
module source_tokenizer import stk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    stk_src_if.sink src,
    stk_res_if.source res
);

    logic push, push_ready, pop_valid, pop;
    burst_t push_data, pop_data;

    stk_front u_front (
        .clk(clk), .rst_n(rst_n), .src(src),
        .push(push), .push_data(push_data), .push_ready(push_ready)
    );

    stk_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data), .push_ready(push_ready),
        .pop_valid(pop_valid), .pop_data(pop_data), .pop(pop)
    );

    stk_back u_back (
        .clk(clk), .rst_n(rst_n),
        .pop_valid(pop_valid), .pop_data(pop_data), .pop(pop), .res(res)
    );

endmodule

>>> dv/source_tokenizer_test.sv
// Testbench for the source tokenizer: drives source bytes, predicts every
// result with a behavioral scanner model and checks the output stream.
// Depends on stk_pkg, stk_if and the source_tokenizer RTL.
module source_tokenizer_test;
    import stk_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    stk_src_if src ();
    stk_res_if res ();

    source_tokenizer dut (.clk(clk), .rst_n(rst_n), .src(src), .res(res));

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct {
        logic [1:0] kind;
        logic [7:0] text_byte;
        logic [5:0] tok_type;
        line_t      tok_line;
        col_t       tok_column;
        logic [1:0] fault_code;
        logic       run_last;
    } tok_result_t;

    tok_result_t pending_results[$];
    tok_result_t step_buf[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 0;
    bit send_gaps = 1;
    bit recv_gaps = 1;
    int hold_off = 0;
    int recv_idle = 0;

    // Scanner state of the model.
    mode_t      m_mode;
    logic [7:0] m_held;
    logic [5:0] m_prev;
    line_t      m_line, m_sline;
    col_t       m_col, m_scol;
    logic [11:0] m_hits;
    logic [2:0] m_wlen;

    function automatic void scanner_reset();
        m_mode = MD_IDLE;
        m_held = 8'd0;
        m_prev = TY_EOF;
        m_line = 1;
        m_col = 1;
        m_sline = 1;
        m_scol = 1;
        m_hits = 12'hFFF;
        m_wlen = 3'd0;
    endfunction

    function automatic void put(logic [1:0] k, logic [7:0] b, logic [5:0] t, line_t l,
                                col_t c, logic [1:0] f);
        tok_result_t r;
        if (step_buf.size() >= MAX_RES)
            return;
        r.kind = k;
        r.text_byte = b;
        r.tok_type = t;
        r.tok_line = l;
        r.tok_column = c;
        r.fault_code = f;
        r.run_last = 1'b0;
        step_buf.push_back(r);
    endfunction

    function automatic void put_text(logic [7:0] b);
        put(K_TEXT, b, TY_EOF, m_sline, m_scol, F_NONE);
    endfunction

    function automatic void put_token_at(logic [5:0] t, line_t l, col_t c);
        put(K_TOKEN, 8'd0, t, l, c, F_NONE);
        m_prev = t;
    endfunction

    function automatic void put_token(logic [5:0] t);
        put_token_at(t, m_sline, m_scol);
    endfunction

    function automatic void put_fault(logic [1:0] f, line_t l, col_t c);
        put(K_ERROR, 8'd0, TY_EOF, l, c, f);
        m_mode = MD_DRAIN;
    endfunction

    function automatic void put_end();
        put(K_END, 8'd0, TY_EOF, m_line, m_col, F_NONE);
        m_mode = MD_DRAIN;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || c == 8'd9 || c == 8'd10 || c == 8'd11 || c == 8'd12 || c == 8'd13;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_wstart(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [5:0] single_op(logic [7:0] c);
        case (c)
            "(": return TY_LPAREN;   ")": return TY_RPAREN;
            "[": return TY_LBRACKET; "]": return TY_RBRACKET;
            "{": return TY_LBRACE;   "}": return TY_RBRACE;
            ",": return TY_COMMA;    ";": return TY_SEMI;
            "+": return TY_PLUS;     "-": return TY_MINUS;
            "*": return TY_STAR;     "/": return TY_SLASH;
            "%": return TY_PERCENT;  "=": return TY_ASSIGN;
            "!": return TY_BANG;     ".": return TY_DOT;
            "<": return TY_LT;       ">": return TY_GT;
            "&": return TY_AMP;      "|": return TY_PIPE;
            "^": return TY_CARET;    "~": return TY_TILDE;
            ":": return TY_COLON;    "@": return TY_AT;
            default: return TY_EOF;
        endcase
    endfunction

    function automatic logic [5:0] pair_op(logic [7:0] a, logic [7:0] b);
        if (a == "-" && b == ">") return TY_ARROW;
        if (a == ":" && b == "=") return TY_DEFINE;
        if (a == ":" && b == ":") return TY_SCOPE;
        if (a == "!" && b == "=") return TY_NEQ;
        if (a == "<" && b == "<") return TY_SHL;
        if (a == "<" && b == "=") return TY_LE;
        if (a == ">" && b == ">") return TY_SHR;
        if (a == ">" && b == "=") return TY_GE;
        if (a == "&" && b == "&") return TY_ANDAND;
        if (a == "|" && b == "|") return TY_OROR;
        return TY_EOF;
    endfunction

    function automatic bit closes_line(logic [5:0] t);
        return t == TY_WORD || t == TY_STRING || t == TY_INT || t == TY_FLOAT ||
               t == TY_BOOL || t == TY_RETURN || t == TY_RPAREN || t == TY_RBRACKET ||
               t == TY_RBRACE;
    endfunction

    function automatic void newline_seen();
        if (m_line != LINE_MAX)
            m_line++;
        if (closes_line(m_prev))
            put_token(TY_SEMI);
        m_mode = MD_IDLE;
    endfunction

    function automatic void word_char(logic [7:0] c);
        for (int i = 0; i < NUM_KW; i++)
            if (!(m_wlen < KW_LEN[i] && KW_CHAR[i][m_wlen] == c))
                m_hits[i] = 1'b0;
        if (m_wlen != 3'd7)
            m_wlen++;
    endfunction

    function automatic logic [5:0] word_class();
        logic [5:0] t;
        t = TY_WORD;
        for (int i = 0; i < NUM_KW; i++)
            if (m_hits[i] && KW_LEN[i] == m_wlen)
                t = KW_TYPE[i];
        return t;
    endfunction

    function automatic void mark_start();
        m_sline = m_line;
        m_scol = m_col;
    endfunction

    function automatic void flush_int_dot();
        col_t dc;
        dc = m_held[0] ? COL_MAX : col_t'(m_col - 1);
        put_token(TY_INT);
        put(K_TEXT, ".", TY_EOF, m_line, dc, F_NONE);
        put_token_at(TY_DOT, m_line, dc);
    endfunction

    function automatic void start_token(logic [7:0] c);
        logic [5:0] t;
        m_mode = MD_IDLE;
        t = single_op(c);
        if (is_blank(c) || c == "#")
        begin
            mark_start();
            if (c == "#") m_mode = MD_COMMENT;
            else if (c == 8'd13) m_mode = MD_AFTER_CR;
            else if (c == 8'd10) newline_seen();
            else m_mode = MD_SPACES;
        end
        else if (c == "?" || c == "$")
            put_end();
        else if (c == "-" || c == ":" || c == "!" || c == "<" || c == ">" || c == "&" ||
                 c == "|")
        begin
            mark_start();
            m_held = c;
            m_mode = MD_OP;
        end
        else if (t != TY_EOF)
        begin
            mark_start();
            put_text(c);
            put_token(t);
        end
        else if (is_digit(c))
        begin
            mark_start();
            put_text(c);
            m_mode = MD_INT;
        end
        else if (is_wstart(c))
        begin
            mark_start();
            m_hits = 12'hFFF;
            m_wlen = 3'd0;
            word_char(c);
            put_text(c);
            m_mode = MD_WORD;
        end
        else if (c == "\"")
        begin
            mark_start();
            m_mode = MD_STR;
        end
        else
            put_fault(F_SYMBOL, m_line, m_col);
    endfunction

    function automatic int escaped(logic [7:0] c);
        case (c)
            "\"": return 34;  "\\": return 92; "b": return 8;  "n": return 10;
            "r": return 13;   "t": return 9;   "v": return 11; "f": return 12;
            default: return 256;
        endcase
    endfunction

    function automatic void scan_byte(logic [7:0] c);
        logic [5:0] t;
        int e;
        case (m_mode)
            MD_IDLE: start_token(c);
            MD_COMMENT:
                if (c == 8'd10) newline_seen();
                else if (c == 8'd13) m_mode = MD_AFTER_CR;
            MD_SPACES:
                if (c == "#")
                begin
                    mark_start();
                    m_mode = MD_COMMENT;
                end
                else if (c == 8'd10) newline_seen();
                else if (c == 8'd13) m_mode = MD_AFTER_CR;
                else if (!is_blank(c)) start_token(c);
            MD_AFTER_CR:
                if (c == 8'd10) newline_seen(); else start_token(c);
            MD_OP:
            begin
                t = pair_op(m_held, c);
                put_text(m_held);
                if (t != TY_EOF)
                begin
                    put_text(c);
                    put_token(t);
                    m_mode = MD_IDLE;
                end
                else
                begin
                    put_token(single_op(m_held));
                    start_token(c);
                end
            end
            MD_INT:
                if (is_digit(c)) put_text(c);
                else if (c == ".")
                begin
                    m_held = {7'd0, m_col == COL_MAX};
                    m_mode = MD_DOT;
                end
                else
                begin
                    put_token(TY_INT);
                    start_token(c);
                end
            MD_DOT:
                if (is_digit(c))
                begin
                    put_text(".");
                    put_text(c);
                    m_mode = MD_FRAC;
                end
                else
                begin
                    flush_int_dot();
                    start_token(c);
                end
            MD_FRAC:
                if (is_digit(c)) put_text(c);
                else
                begin
                    put_token(TY_FLOAT);
                    start_token(c);
                end
            MD_WORD:
                if (is_wstart(c) || is_digit(c))
                begin
                    word_char(c);
                    put_text(c);
                end
                else
                begin
                    put_token(word_class());
                    start_token(c);
                end
            MD_STR:
                if (c == "\"")
                begin
                    put_token(TY_STRING);
                    m_mode = MD_IDLE;
                end
                else if (c == 8'd10 || c == 8'd13) put_fault(F_NEWLINE, m_sline, m_scol);
                else if (c == "\\") m_mode = MD_ESC;
                else put_text(c);
            MD_ESC:
            begin
                e = escaped(c);
                if (e < 256)
                begin
                    put_text(e[7:0]);
                    m_mode = MD_STR;
                end
                else
                    put_fault(F_ESCAPE, m_sline, m_scol);
            end
            default: ;
        endcase
    endfunction

    function automatic void close_source();
        case (m_mode)
            MD_OP:
            begin
                put_text(m_held);
                put_token(single_op(m_held));
                put_end();
            end
            MD_INT:
            begin
                put_token(TY_INT);
                put_end();
            end
            MD_DOT:
            begin
                flush_int_dot();
                put_end();
            end
            MD_FRAC:
            begin
                put_token(TY_FLOAT);
                put_end();
            end
            MD_WORD:
            begin
                put_token(word_class());
                put_end();
            end
            MD_STR: put_fault(F_UNTERM, m_sline, m_scol);
            MD_ESC: put_fault(F_ESCAPE, m_sline, m_scol);
            MD_DRAIN: ;
            default: put_end();
        endcase
    endfunction

    // Predicts all results of one source byte and queues them.
    function automatic void predict_byte(logic [7:0] c, logic eos);
        step_buf.delete();
        if (c != 8'd0 && m_mode != MD_DRAIN)
        begin
            scan_byte(c);
            if (c == 8'd10) m_col = 1;
            else if (m_col != COL_MAX) m_col++;
        end
        if (c == 8'd0 || eos)
        begin
            close_source();
            scanner_reset();
        end
        if (step_buf.size() > 0)
            step_buf[step_buf.size()-1].run_last = 1'b1;
        foreach (step_buf[i])
            pending_results.push_back(step_buf[i]);
    endfunction

    // Starts and ends at a falling edge; valid stays high between back-to-back
    // requests and is dropped only for a gap or by wait_drained.
    task automatic send_byte(logic [7:0] c, logic eos);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            src.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        src.valid <= 1'b1;
        src.src_byte <= c;
        src.end_of_source <= eos;
        @(posedge clk);
        while (!src.ready)
            @(posedge clk);
        predict_byte(c, eos);
        @(negedge clk);
    endtask

    task automatic send_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], close && i == s.len() - 1);
    endtask

    task automatic wait_drained();
        src.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Receiver: random stall bursts, or a long hold-off when requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_off > 0)
        begin
            res.ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else if (recv_idle > 0)
        begin
            res.ready <= 1'b0;
            recv_idle <= recv_idle - 1;
        end
        else if (recv_gaps && $urandom_range(0, 7) == 0)
        begin
            res.ready <= 1'b0;
            recv_idle <= $urandom_range(0, 15);
        end
        else
            res.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (src.valid && src.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge clk)
    begin
        tok_result_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d at %0t", res.kind, $realtime);
            end
            else
            begin
                e = pending_results.pop_front();
                if (res.kind !== e.kind || res.text_byte !== e.text_byte ||
                    res.tok_type !== e.tok_type || res.tok_line !== e.tok_line ||
                    res.tok_column !== e.tok_column || res.fault_code !== e.fault_code ||
                    res.run_last !== e.run_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp k%0d b%h t%0d l%0d c%0d f%0d r%0d / got k%0d b%h t%0d l%0d c%0d f%0d r%0d",
                                 e.kind, e.text_byte, e.tok_type, e.tok_line, e.tok_column,
                                 e.fault_code, e.run_last, res.kind, res.text_byte,
                                 res.tok_type, res.tok_line, res.tok_column,
                                 res.fault_code, res.run_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles > 20000 && !timed_out)
        begin
            timed_out = 1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_tokens();
        send_text("x:=3.25+f_1->a::b!=c<=d>=e<<f>>g&&h||i\n", 0);
        send_text("func(){return[1,2]}true false None using mut if else while type\n", 0);
        send_text("s=\"a\\n\\t\\\"\\\\\\b\\r\\v\\f\";%*/^~@&|!<>:-\n", 0);
        send_text("12. 7.x 3 # n\r\n x \r y", 1);
    endtask

    task automatic test_faults();
        send_text("\"abc", 1);
        send_text("\"a\nzz", 1);
        send_text("\"a\\q\"", 1);
        send_text("\"a\\", 1);
        send_byte(8'd128, 0);
        send_byte(8'hFF, 1);
        send_text("a ? b", 1);
        send_text("1 $", 1);
        send_text("x # open comment", 1);
        send_byte(8'd1, 0);
        send_byte(8'd0, 0);
    endtask

    function automatic logic [7:0] pick_byte();
        string alphabet;
        alphabet = "abcdefgilmnoprstuvwxyNT_0123456789 \t\n\r#\"\\.()[]{},;+-*/%=!<>&|^~:@";
        case ($urandom_range(0, 19))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(128, 255));
            default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
        endcase
    endfunction

    task automatic test_random();
        string words[$];
        words = '{"let ", "x1 ", ":= ", "42", "3.75", "\"hi\\n\" ", "return", ")\n", "} ",
                  "true", "while ", "# c\n", "->", "None", "\r\n", "a.b", "_k9 "};
        for (int n = 0; n < 16; n++)
        begin
            if (n == 4)
            begin
                hold_off <= 200;
                for (int k = 0; k < 8; k++)
                    send_text(words[$urandom_range(0, words.size() - 1)], 0);
            end
            if (n == 8)
                wait_drained();
            if (n == 12)
            begin
                send_gaps = 0;
                recv_gaps = 0;
            end
            if ($urandom_range(0, 3) != 0)
                send_text(words[$urandom_range(0, words.size() - 1)],
                          $urandom_range(0, 30) == 0);
            else
                send_byte(pick_byte(), $urandom_range(0, 30) == 0);
        end
        send_byte("\n", 1);
    endtask

    initial
    begin
        src.valid = 1'b0;
        src.src_byte = 8'd0;
        src.end_of_source = 1'b0;
        res.ready = 1'b0;
        scanner_reset();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_tokens();
        test_faults();
        wait_drained();
        test_random();
        wait_drained();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/stk_pkg.sv
hw/rtl/stk_if.sv
hw/rtl/stk_front.sv
hw/rtl/stk_queue.sv
hw/rtl/stk_back.sv
hw/rtl/source_tokenizer.sv
dv/source_tokenizer_test.sv
